@@ rtl/pcbs_pkg.sv @@
// ---------------------------------------------------------------------------
// pcbs_pkg
// Shared types and constants for the per-class box suppression block.
// ---------------------------------------------------------------------------
package pcbs_pkg;

  localparam logic [6:0] MAX_RESULTS = 7'd64;

  // Register indexes on the configuration port
  localparam logic REG_IOU_THRESHOLD = 1'b0;
  localparam logic REG_KEEP_COUNT    = 1'b1;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [7:0]  class_id;
    logic [15:0] score;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_center_x;
    logic [15:0] out_center_y;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [7:0]  out_class;
    logic [15:0] out_score;
    logic        last_out;
    logic        empty_res;
    logic        overflow;
  } out_item_t;

  // One stored detection
  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  cls;
    logic [15:0] score;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic store;
    logic sup_init;
    logic i_next;
    logic j_set;
    logic j_inc;
    logic cap_i;
    logic stage1;
    logic stage2;
    logic stage3;
    logic zero_i;
    logic zero_j;
    logic e_init;
    logic e_take;
    logic e_fin;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic i_last;
    logic j_last;
    logic a_zero;
    logic pair_ok;
    logic hit;
    logic lose_i;
    logic e_none;
    logic e_done;
  } sts_t;

endpackage

@@ rtl/pcbs_ram.sv @@
// ---------------------------------------------------------------------------
// pcbs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module pcbs_ram #(
  parameter int WIDTH = 88,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when we is high; read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/pcbs_dp.sv @@
// ---------------------------------------------------------------------------
// pcbs_dp
// Datapath: detection store, pair indexes, overlap test pipeline and
// result register.
// ---------------------------------------------------------------------------
module pcbs_dp
  import pcbs_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  logic [15:0] thr,
  input  logic [6:0]  keep,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [6:0]    emitted_r, emitted_nxt;
  entry_t        ei_r, ei_nxt;
  entry_t        ej_r;
  entry_t        pend_r;
  logic [17:0]   ox_r, oy_r;
  logic          olap_ok_r;
  logic [35:0]   inter_r;
  logic [31:0]   ara_r, arb_r;
  logic [51:0]   lhs_r, rhs_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;

  entry_t          rd_a, rd_b, wdata, in_entry;
  logic            we, room;
  logic [AW-1:0]   waddr;
  logic [6:0]      limit;
  logic            surv;
  logic [6:0]      emitted_inc;
  logic [CW:0]     i_plus, j_plus;

  logic signed [19:0] l1x, l2x, r1x, r2x, l1y, l2y, r1y, r2y;
  logic signed [19:0] ox, oy;
  logic [35:0]        uni;

  assign in_entry = '{cx: in_item.center_x, cy: in_item.center_y, w: in_item.box_width,
                      h: in_item.box_height, cls: in_item.class_id, score: in_item.score};

  // Store write port: load, or erase a score
  assign room = (count_r < CW'(CAPACITY));
  assign we   = (cmd.store && room) || cmd.zero_i || cmd.zero_j;
  always_comb begin
    waddr = j_r[AW-1:0];
    wdata = '{cx: ej_r.cx, cy: ej_r.cy, w: ej_r.w, h: ej_r.h, cls: ej_r.cls, score: 16'd0};
    if (cmd.store) begin
      waddr = count_r[AW-1:0];
      wdata = in_entry;
    end else if (cmd.zero_i) begin
      waddr = i_r[AW-1:0];
      wdata = '{cx: ei_r.cx, cy: ei_r.cy, w: ei_r.w, h: ei_r.h, cls: ei_r.cls, score: 16'd0};
    end
  end

  // Two copies of the store give the i and j reads
  pcbs_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_ram_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(i_r[AW-1:0]), .rdata(rd_a)
  );

  pcbs_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_ram_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(j_r[AW-1:0]), .rdata(rd_b)
  );

  // Box edges on the doubled scale
  always_comb begin
    l1x = $signed({3'b0, ei_r.cx, 1'b0}) - $signed({4'b0, ei_r.w});
    r1x = $signed({3'b0, ei_r.cx, 1'b0}) + $signed({4'b0, ei_r.w});
    l2x = $signed({3'b0, rd_b.cx, 1'b0}) - $signed({4'b0, rd_b.w});
    r2x = $signed({3'b0, rd_b.cx, 1'b0}) + $signed({4'b0, rd_b.w});
    l1y = $signed({3'b0, ei_r.cy, 1'b0}) - $signed({4'b0, ei_r.h});
    r1y = $signed({3'b0, ei_r.cy, 1'b0}) + $signed({4'b0, ei_r.h});
    l2y = $signed({3'b0, rd_b.cy, 1'b0}) - $signed({4'b0, rd_b.h});
    r2y = $signed({3'b0, rd_b.cy, 1'b0}) + $signed({4'b0, rd_b.h});
    ox  = ((r1x < r2x) ? r1x : r2x) - ((l1x > l2x) ? l1x : l2x);
    oy  = ((r1y < r2y) ? r1y : r2y) - ((l1y > l2y) ? l1y : l2y);
    uni = {2'b0, ara_r, 2'b0} + {2'b0, arb_r, 2'b0} - inter_r;
  end

  // Status
  assign i_plus       = {1'b0, i_r} + (CW+1)'(1);
  assign j_plus       = {1'b0, j_r} + (CW+1)'(1);
  assign limit        = (keep > MAX_RESULTS) ? MAX_RESULTS : keep;
  assign surv         = (rd_a.score != 16'd0);
  assign emitted_inc  = emitted_r + {6'd0, surv};
  assign sts.i_last   = (i_plus >= {1'b0, count_r});
  assign sts.j_last   = (j_plus >= {1'b0, count_r});
  assign sts.a_zero   = !surv;
  assign sts.pair_ok  = (rd_b.score != 16'd0) && (rd_b.cls == ei_r.cls);
  assign sts.hit      = (lhs_r > rhs_r);
  assign sts.lose_i   = (ei_r.score < ej_r.score);
  assign sts.e_none   = (count_r == '0) || (limit == 7'd0);
  assign sts.e_done   = sts.i_last || (emitted_inc == limit);

  // Control-side register updates
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    emitted_nxt   = emitted_r;
    ei_nxt        = ei_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (cmd.store) begin
      if (room) begin
        count_nxt = count_r + CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.sup_init || cmd.e_init) begin
      i_nxt = '0;
    end
    if (cmd.e_init) begin
      emitted_nxt = '0;
    end
    if (cmd.i_next || cmd.e_take) begin
      i_nxt = i_plus[CW-1:0];
    end
    if (cmd.j_set) begin
      j_nxt = i_plus[CW-1:0];
    end
    if (cmd.j_inc) begin
      j_nxt = j_plus[CW-1:0];
    end
    if (cmd.cap_i) begin
      ei_nxt = rd_a;
    end
    if (cmd.zero_i) begin
      ei_nxt.score = 16'd0;
    end
    // Hold one survivor back so the final one can carry last_out
    if (cmd.e_take && surv) begin
      emitted_nxt = emitted_inc;
      if (emitted_r != 7'd0) begin
        out_valid_nxt = 1'b1;
        out_nxt = '{out_center_x: pend_r.cx, out_center_y: pend_r.cy,
                    out_width: pend_r.w, out_height: pend_r.h, out_class: pend_r.cls,
                    out_score: pend_r.score, last_out: 1'b0, empty_res: 1'b0,
                    overflow: ovf_r};
      end
    end
    if (cmd.e_fin) begin
      out_valid_nxt = 1'b1;
      if (emitted_r != 7'd0) begin
        out_nxt = '{out_center_x: pend_r.cx, out_center_y: pend_r.cy,
                    out_width: pend_r.w, out_height: pend_r.h, out_class: pend_r.cls,
                    out_score: pend_r.score, last_out: 1'b1, empty_res: 1'b0,
                    overflow: ovf_r};
      end else begin
        out_nxt = '{out_center_x: 16'd0, out_center_y: 16'd0, out_width: 16'd0,
                    out_height: 16'd0, out_class: 8'd0, out_score: 16'd0,
                    last_out: 1'b1, empty_res: 1'b1, overflow: ovf_r};
      end
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      emitted_r   <= '0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      emitted_r   <= emitted_nxt;
    end
  end

  // Payload registers and the overlap pipeline
  always_ff @(posedge clk) begin
    ei_r  <= ei_nxt;
    out_r <= out_nxt;
    if (cmd.e_take && surv) begin
      pend_r <= rd_a;
    end
    if (cmd.stage1) begin
      ej_r      <= rd_b;
      ox_r      <= ox[17:0];
      oy_r      <= oy[17:0];
      olap_ok_r <= !ox[19] && !oy[19];
    end
    if (cmd.stage2) begin
      inter_r <= olap_ok_r ? (36'(ox_r) * 36'(oy_r)) : 36'd0;
      ara_r   <= 32'(ei_r.w) * 32'(ei_r.h);
      arb_r   <= 32'(ej_r.w) * 32'(ej_r.h);
    end
    if (cmd.stage3) begin
      lhs_r <= {inter_r, 16'd0};
      rhs_r <= 52'(thr) * 52'(uni);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.e_fin |=> out_valid && out_item.last_out)
    else $error("end of set without final item");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.empty_res |-> out_item.last_out && out_item.out_score == 16'd0)
    else $error("empty item malformed");

endmodule

@@ rtl/pcbs_ctrl.sv @@
// ---------------------------------------------------------------------------
// pcbs_ctrl
// Controller: sequences load, pairwise suppression and survivor output.
// ---------------------------------------------------------------------------
module pcbs_ctrl
  import pcbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic last_in,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  typedef enum logic [3:0] {
    S_LOAD, S_I_START, S_I_LOAD, S_J_CHK, S_J_WAIT,
    S_M1, S_M2, S_CMP, S_E_WAIT, S_E_RD, S_E_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_LOAD: begin
        if (start) begin
          cmd.store = 1'b1;
          if (last_in) begin
            cmd.sup_init = 1'b1;
            state_nxt    = S_I_START;
          end
        end
      end
      S_I_START: begin
        if (sts.i_last) begin
          cmd.e_init = 1'b1;
          state_nxt  = sts.e_none ? S_E_FIN : S_E_WAIT;
        end else begin
          cmd.j_set = 1'b1;
          state_nxt = S_I_LOAD;
        end
      end
      S_I_LOAD: begin
        cmd.cap_i = 1'b1;
        if (sts.a_zero) begin
          cmd.i_next = 1'b1;
          state_nxt  = S_I_START;
        end else begin
          state_nxt = S_J_CHK;
        end
      end
      S_J_CHK: begin
        if (sts.pair_ok) begin
          cmd.stage1 = 1'b1;
          state_nxt  = S_M1;
        end else if (sts.j_last) begin
          cmd.i_next = 1'b1;
          state_nxt  = S_I_START;
        end else begin
          cmd.j_inc = 1'b1;
          state_nxt = S_J_WAIT;
        end
      end
      S_J_WAIT: state_nxt = S_J_CHK;
      S_M1: begin
        cmd.stage2 = 1'b1;
        state_nxt  = S_M2;
      end
      S_M2: begin
        cmd.stage3 = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        // Drop the lower score; an erased i ends its row
        if (sts.hit && sts.lose_i) begin
          cmd.zero_i = 1'b1;
          cmd.i_next = 1'b1;
          state_nxt  = S_I_START;
        end else begin
          cmd.zero_j = sts.hit;
          if (sts.j_last) begin
            cmd.i_next = 1'b1;
            state_nxt  = S_I_START;
          end else begin
            cmd.j_inc = 1'b1;
            state_nxt = S_J_WAIT;
          end
        end
      end
      S_E_WAIT: state_nxt = S_E_RD;
      S_E_RD: begin
        cmd.e_take = 1'b1;
        state_nxt  = sts.e_done ? S_E_FIN : S_E_WAIT;
      end
      S_E_FIN: begin
        cmd.e_fin = 1'b1;
        state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_LOAD);

  a_one_erase: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.zero_i && cmd.zero_j))
    else $error("both boxes of a pair erased");

  a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> !busy)
    else $error("item stored while busy");

  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> $past(state_r == S_E_FIN))
    else $error("set ended without output");

endmodule

@@ rtl/per_class_box_suppression.sv @@
// ---------------------------------------------------------------------------
// per_class_box_suppression
// Per-class non-maximum suppression on IoU over a stored set of boxes.
// ---------------------------------------------------------------------------
// Each item is taken in a cycle with start high while busy is low; the item with last_in
// set makes busy rise for the suppression and output of the set. The pair
// scan walks each row, skips pairs of other classes or erased boxes, and
// runs each compared pair through store reads, two multiplier stages and
// the compare; output then scans the stored entries in order up to the keep count.
// Results come one per strobe on out_valid and cannot be stalled; the last
// result leaves in the cycle in which busy falls.
// ---------------------------------------------------------------------------
module per_class_box_suppression
  import pcbs_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] thr_r;
  logic [6:0]  keep_r;
  cmd_t        cmd;
  sts_t        sts;
  logic        cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 16'd29491;
      keep_r <= 7'd64;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_IOU_THRESHOLD) begin
        thr_r <= pwdata[15:0];
      end else begin
        keep_r <= pwdata[6:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_KEEP_COUNT) ? {25'd0, keep_r} : {16'd0, thr_r};

  pcbs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .last_in(in_item.last_in),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  pcbs_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .sts(sts),
    .thr(thr_r), .keep(keep_r), .out_valid(out_valid), .out_item(out_item)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives detection sets into the per-class box suppression block, predicts
// the surviving boxes after same-class IoU suppression and checks each
// emitted result item against the prediction, over several register settings.
// ---------------------------------------------------------------------------
module testbench;
  import pcbs_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int SETTLE_CYCLES = 40;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  per_class_box_suppression dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Predictor state
  logic [15:0] thr_model;
  logic [6:0]  keep_model;
  entry_t      det_store [STORE_DEPTH];
  int          det_count;
  logic        dropped_any;

  in_item_t    pending_items[$];
  out_item_t   expected_survivors[$];
  int          mismatches;
  int          checked;
  int          sets_sent;
  int          items_sent;
  logic        took;
  int          gap_left;
  logic        quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1500000;
    $display("Timeout waiting for results");
    $display("Simulation FAILED");
    $finish;
  end

  // Overlap along one axis on the doubled scale
  function automatic longint axis_span(logic [15:0] c1, logic [15:0] w1,
                                       logic [15:0] c2, logic [15:0] w2);
    longint l1, l2, r1, r2, lo, hi;
    l1 = 2 * longint'(c1) - longint'(w1);
    l2 = 2 * longint'(c2) - longint'(w2);
    r1 = 2 * longint'(c1) + longint'(w1);
    r2 = 2 * longint'(c2) + longint'(w2);
    lo = (l1 > l2) ? l1 : l2;
    hi = (r1 < r2) ? r1 : r2;
    return hi - lo;
  endfunction

  function automatic bit too_close(entry_t a, entry_t b);
    longint ox, oy, inter, uni;
    ox = axis_span(a.cx, a.w, b.cx, b.w);
    oy = axis_span(a.cy, a.h, b.cy, b.h);
    inter = (ox >= 0 && oy >= 0) ? ox * oy : 0;
    uni = 4 * longint'(a.w) * longint'(a.h) + 4 * longint'(b.w) * longint'(b.h) - inter;
    return inter * 65536 > longint'(thr_model) * uni;
  endfunction

  // Store one detection; on the last one suppress and queue the survivors
  task automatic predict_detection(in_item_t it);
    out_item_t r;
    int lim, n;
    if (det_count < STORE_DEPTH) begin
      det_store[det_count] = '{it.center_x, it.center_y, it.box_width,
                               it.box_height, it.class_id, it.score};
      det_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (!it.last_in) return;
    for (int i = 0; i < det_count; i++) begin
      for (int j = i + 1; j < det_count; j++) begin
        if (det_store[i].score == 0) break;
        if (det_store[j].score == 0 || det_store[i].cls != det_store[j].cls) continue;
        if (too_close(det_store[i], det_store[j])) begin
          if (det_store[i].score < det_store[j].score) det_store[i].score = '0;
          else det_store[j].score = '0;
        end
      end
    end
    lim = (keep_model > MAX_RESULTS) ? int'(MAX_RESULTS) : int'(keep_model);
    n = 0;
    for (int i = 0; i < det_count && n < lim; i++) begin
      if (det_store[i].score == 0) continue;
      r = '0;
      r.out_center_x = det_store[i].cx;
      r.out_center_y = det_store[i].cy;
      r.out_width    = det_store[i].w;
      r.out_height   = det_store[i].h;
      r.out_class    = det_store[i].cls;
      r.out_score    = det_store[i].score;
      r.overflow     = dropped_any;
      expected_survivors.insert(expected_survivors.size(), r);
      n++;
    end
    if (n == 0) begin
      r = '0;
      r.empty_res = 1'b1;
      r.last_out  = 1'b1;
      r.overflow  = dropped_any;
      expected_survivors.insert(expected_survivors.size(), r);
    end else begin
      expected_survivors[$].last_out = 1'b1;
    end
    det_count = 0;
    dropped_any = 1'b0;
  endtask

  // Predict accepted items, check emitted results
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n) begin
      took <= start && !busy;
      if (start && !busy) predict_detection(in_item);
      if (out_valid) begin
        checked++;
        if (expected_survivors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result item %p", out_item);
        end else begin
          exp_r = expected_survivors.pop_front();
          if (out_item.out_center_x !== exp_r.out_center_x ||
              out_item.out_center_y !== exp_r.out_center_y ||
              out_item.out_width !== exp_r.out_width ||
              out_item.out_height !== exp_r.out_height ||
              out_item.out_class !== exp_r.out_class ||
              out_item.out_score !== exp_r.out_score ||
              out_item.last_out !== exp_r.last_out ||
              out_item.empty_res !== exp_r.empty_res ||
              out_item.overflow !== exp_r.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch at %0t: expected %p, got %p", $realtime, exp_r, out_item);
          end
        end
      end
    end else begin
      took <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present the next item; hold it until taken
  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
        gap_left <= pick_gap();
        items_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == {REG_IOU_THRESHOLD, 2'b00}) thr_model = value[15:0];
    else if (addr == {REG_KEEP_COUNT, 2'b00}) keep_model = value[6:0];
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !start && !busy && expected_survivors.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] thr, logic [6:0] keep);
    drain();
    write_reg({REG_IOU_THRESHOLD, 2'b00}, {16'h0, thr});
    write_reg({REG_KEEP_COUNT, 2'b00}, {25'h0, keep});
  endtask

  function automatic in_item_t any_item();
    logic [95:0] raw;
    in_item_t it;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.last_in = 1'b0;
    return it;
  endfunction

  // Append one item to the drive queue
  task automatic add_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // Queue one set; when clustered, most boxes fall in three classes so suppression happens
  task automatic queue_set(int n, bit clustered);
    in_item_t base, it;
    base = any_item();
    base.box_width = 16'($urandom_range(64, 8000));
    base.box_height = 16'($urandom_range(64, 8000));
    for (int k = 0; k < n; k++) begin
      if (clustered && $urandom_range(0, 9) != 0) begin
        it = base;
        it.center_x   = base.center_x + 16'($urandom_range(0, 600)) - 16'd300;
        it.center_y   = base.center_y + 16'($urandom_range(0, 600)) - 16'd300;
        it.box_width  = base.box_width + 16'($urandom_range(0, 400));
        it.box_height = base.box_height + 16'($urandom_range(0, 400));
        it.class_id   = 8'($urandom_range(0, 2)) + base.class_id;
        it.score      = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
      end else begin
        it = any_item();
      end
      it.last_in = (k == n - 1);
      add_item(it);
    end
    sets_sent++;
  endtask

  function automatic in_item_t make_box(logic [15:0] cx, logic [15:0] cy, logic [15:0] w,
                                        logic [15:0] h, logic [7:0] cls, logic [15:0] sc,
                                        logic last);
    return '{cx, cy, w, h, cls, sc, last};
  endfunction

  initial begin
    int n;
    rst_n = 1'b0; start = 1'b0; in_item = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    thr_model = 16'd29491; keep_model = 7'd64;
    det_count = 0; dropped_any = 1'b0; gap_left = 0; quiet = 1'b0;
    mismatches = 0; checked = 0; sets_sent = 0; items_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, zero scores, ties, class split, zero area
    add_item(make_box('1, '1, '1, '1, '1, '1, 1'b0));
    add_item(make_box('1, '1, '1, '1, '1, '1, 1'b0));
    add_item(make_box('0, '0, '0, '0, '0, '0, 1'b0));
    add_item(make_box(16'h1000, 16'h1000, 16'h0800, 16'h0800, 8'd3, 16'd500, 1'b0));
    add_item(make_box(16'h1010, 16'h1000, 16'h0800, 16'h0800, 8'd3, 16'd900, 1'b0));
    add_item(make_box(16'h1000, 16'h1000, 16'h0800, 16'h0800, 8'd4, 16'd100, 1'b1));
    sets_sent++;
    add_item(make_box(16'h2000, 16'h2000, 16'h0, 16'h0, 8'd1, 16'd7, 1'b0));
    add_item(make_box(16'h2000, 16'h2000, 16'h0, 16'h0, 8'd1, 16'd7, 1'b1));
    sets_sent++;
    add_item(make_box(16'h0, 16'h0, 16'h0, 16'h0, 8'd0, 16'd0, 1'b1));
    sets_sent++;
    add_item(make_box(16'h0, '1, '1, 16'h0, 8'd9, 16'd1, 1'b1));
    sets_sent++;

    configure(16'd0, 7'd1);
    quiet = 1'b1;
    queue_set(6, 1);
    quiet = 1'b0;
    configure(16'hFFFF, 7'd0);
    queue_set(4, 1);
    configure(16'hFFFF, 7'd64);
    queue_set(5, 1);

    // Random sets over several register settings, one overflowing set
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: configure(16'd29491, 7'd64);
        1: configure(16'd0, 7'd3);
        2: configure(16'($urandom), 7'd127);
        3: configure(16'd65535, 7'd64);
        default: configure(16'($urandom_range(8000, 50000)), 7'($urandom_range(0, 64)));
      endcase
      quiet = (ph == 3);
      if (ph == 2) queue_set(70, 1);
      for (int s = 0; s < 5; s++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        queue_set(n, $urandom_range(0, 3) != 0);
      end
    end

    drain();
    $display("Sent %0d detection items in %0d sets; checked %0d result items",
             items_sent, sets_sent, checked);
    $display("Covered threshold and keep-count extremes, ties, zero scores and overflow");
    if (mismatches == 0 && expected_survivors.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
